// ===== design/tsps_pkg.sv =====
// Package for the per-symbol tick statistics block.
// Holds the record layout, sizes and state codes; depends on nothing else.
`timescale 1ns / 1ps

package tsps_pkg;

  localparam int NUM_SYMBOLS = 256;
  localparam int SYM_W       = 8;
  localparam int WINDOW      = 3;
  localparam int PTR_W       = 2;

  localparam logic [13:0] THRESH_RESET = 14'd80;
  localparam logic [13:0] BP_SCALE     = 14'd10000;
  localparam logic [26:0] DD_SCALE     = 27'd100000000;

  // Divider dividend widths for the three quotients.
  localparam logic [6:0] VW_BITS   = 7'd64;
  localparam logic [6:0] DD_BITS   = 7'd59;
  localparam logic [6:0] MEAN_BITS = 7'd34;

  // One statistics record per symbol.
  typedef struct packed {
    logic [47:0]             vol_sum;
    logic [63:0]             notional;
    logic [WINDOW-1:0][31:0] win;
    logic [1:0]              fill;
    logic [PTR_W-1:0]        ptr;
    logic [31:0]             prev;
    logic [31:0]             peak;
    logic [26:0]             dd;
    logic [31:0]             anom;
  } rec_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_CALC,
    ST_MUL,
    ST_DIV,
    ST_DONE
  } state_e;

  typedef enum logic [1:0] {
    OP_VWAP,
    OP_DD,
    OP_MEAN
  } div_op_e;

endpackage

// ===== design/tick_stats_per_symbol.sv =====
// Top level of the per-symbol tick statistics block.
// Uses tsps_pkg for the record layout, constants and state codes.
`timescale 1ns / 1ps
//
//  channel  | handshake                 | payload
//  ---------+---------------------------+------------------------------------------
//  input    | in_valid_i / in_stall_o   | symbol_id_i, price_i, volume_i
//  output   | out_valid_o / out_stall_i | out_symbol_o .. jump_flag_o
//  config   | cfg_we_i                  | cfg_wdata_i (anomaly threshold)
//
// A tick occupies the block from the accept cycle through record read, update and products,
// the shared radix-2 divider (64 + 59 + 34 steps, each quotient loaded on the last step of
// the one before) and the write-back cycle.
// Reset clears the per-entry valid bits at once; an invalid entry reads as zeros.
// A finished result waits in the output register; the next tick is taken meanwhile, and
// write-back waits while an earlier result is still stalled.

module tick_stats_per_symbol
  import tsps_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [13:0]       cfg_wdata_i,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [SYM_W-1:0]  symbol_id_i,
  input  logic [31:0]       price_i,
  input  logic [23:0]       volume_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [SYM_W-1:0]  out_symbol_o,
  output logic [47:0]       volume_total_o,
  output logic [31:0]       vwap_o,
  output logic [31:0]       rolling_mean_o,
  output logic [31:0]       anomalies_o,
  output logic [26:0]       drawdown_max_o,
  output logic              jump_flag_o
);

  // Configuration register.
  logic [13:0] thresh_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thresh_q <= THRESH_RESET;
    end else if (cfg_we_i) begin
      thresh_q <= cfg_wdata_i;
    end
  end

  // Control state.
  state_e  state_q, state_d;
  div_op_e op_q;
  logic [6:0] cnt_q;
  logic out_free;
  logic accept;
  logic div_last;

  assign out_free = !out_valid_o || !out_stall_i;
  assign div_last = (cnt_q == 7'd1);

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: if (in_valid_i) state_d = ST_READ;
      ST_READ: state_d = ST_CALC;
      ST_CALC: state_d = ST_MUL;
      ST_MUL:  state_d = ST_DIV;
      ST_DIV:  if (div_last && op_q == OP_MEAN) state_d = ST_DONE;
      ST_DONE: if (out_free) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // Outputs of the state machine.
  always_comb begin
    in_stall_o = (state_q != ST_IDLE);
  end

  assign accept = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Record memory with registered read, plus per-entry valid bits.
  rec_t mem [NUM_SYMBOLS];
  logic [NUM_SYMBOLS-1:0] valid_q;
  rec_t rd_q;
  logic rd_valid_q;
  logic mem_we;
  rec_t wr_rec;
  logic [SYM_W-1:0] sym_q;

  assign mem_we = (state_q == ST_DONE) && out_free;

  always_ff @(posedge clk_i) begin
    if (accept) begin
      rd_q <= mem[symbol_id_i];
    end
    if (mem_we) begin
      mem[sym_q] <= wr_rec;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= '0;
      rd_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        rd_valid_q <= valid_q[symbol_id_i];
      end
      if (mem_we) begin
        valid_q[sym_q] <= 1'b1;
      end
    end
  end

  // Transaction capture and the notional product.
  logic [31:0] price_q;
  logic [23:0] vol_q;
  logic [55:0] prod_q;
  always_ff @(posedge clk_i) begin
    if (accept) begin
      sym_q   <= symbol_id_i;
      price_q <= price_i;
      vol_q   <= volume_i;
    end
    if (state_q == ST_READ) begin
      prod_q <= 56'(price_q) * 56'(vol_q);
    end
  end

  // Update of sums, window, peak and anomaly products.
  rec_t old_rec;
  rec_t new_d;
  rec_t new_q;
  logic [48:0] vsum_w;
  logic [64:0] nsum_w;
  logic [PTR_W-1:0] ptr_w;
  logic [31:0] peak_w;
  logic [31:0] diff_w;
  logic [45:0] lhs_q, rhs_q;
  logic last_nz_q;

  assign old_rec = rd_valid_q ? rd_q : '0;

  always_comb begin
    vsum_w = 49'(old_rec.vol_sum) + 49'(vol_q);
    nsum_w = 65'(old_rec.notional) + 65'(prod_q);
    ptr_w  = (old_rec.ptr >= PTR_W'(WINDOW)) ? '0 : old_rec.ptr;
    peak_w = (price_q > old_rec.peak) ? price_q : old_rec.peak;
    diff_w = (price_q >= old_rec.prev) ? price_q - old_rec.prev : old_rec.prev - price_q;
  end

  // Updated record before the anomaly count and drawdown are settled.
  always_comb begin
    new_d            = old_rec;
    new_d.vol_sum    = vsum_w[48] ? '1 : vsum_w[47:0];
    new_d.notional   = nsum_w[64] ? '1 : nsum_w[63:0];
    new_d.win[ptr_w] = price_q;
    new_d.ptr        = (ptr_w == PTR_W'(WINDOW - 1)) ? '0 : ptr_w + 1'b1;
    new_d.fill       = (old_rec.fill < 2'(WINDOW)) ? old_rec.fill + 1'b1 : old_rec.fill;
    new_d.peak       = peak_w;
    new_d.prev       = price_q;
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_CALC) begin
      new_q     <= new_d;
      lhs_q     <= 46'(diff_w) * 46'(BP_SCALE);
      rhs_q     <= 46'(thresh_q) * 46'(old_rec.prev);
      last_nz_q <= (old_rec.prev != '0);
    end
  end

  // Anomaly decision, window sum and drawdown numerator.
  logic jump_q;
  logic [31:0] anom_q;
  logic [33:0] wsum_q;
  logic [58:0] ddnum_q;
  logic jump_w;
  logic [33:0] wsum_w;

  always_comb begin
    jump_w = last_nz_q && (lhs_q >= rhs_q);
    wsum_w = '0;
    for (int i = 0; i < WINDOW; i++) begin
      if (2'(i) < new_q.fill) begin
        wsum_w = wsum_w + 34'(new_q.win[i]);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_MUL) begin
      jump_q  <= jump_w;
      anom_q  <= (jump_w && new_q.anom != '1) ? new_q.anom + 1'b1 : new_q.anom;
      wsum_q  <= wsum_w;
      ddnum_q <= 59'(new_q.peak - price_q) * 59'(DD_SCALE);
    end
  end

  // Shared restoring divider, one quotient bit per cycle.
  logic [63:0] quo_q;
  logic [47:0] rem_q;
  logic [47:0] den_q;
  logic [48:0] rem_sh;
  logic        fit;
  logic [63:0] quo_next;
  logic [31:0] vwap_q, mean_q;
  logic [26:0] dd_q;

  always_comb begin
    rem_sh   = {rem_q, quo_q[63]};
    fit      = (rem_sh >= 49'(den_q));
    quo_next = {quo_q[62:0], fit};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      op_q  <= OP_VWAP;
      cnt_q <= '0;
    end else if (state_q == ST_MUL) begin
      op_q  <= OP_VWAP;
      cnt_q <= VW_BITS;
    end else if (state_q == ST_DIV) begin
      if (div_last) begin
        case (op_q)
          OP_VWAP: begin
            op_q  <= OP_DD;
            cnt_q <= DD_BITS;
          end
          OP_DD: begin
            op_q  <= OP_MEAN;
            cnt_q <= MEAN_BITS;
          end
          default: cnt_q <= '0;
        endcase
      end else begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_MUL) begin
      quo_q <= new_q.notional;
      rem_q <= '0;
      den_q <= new_q.vol_sum;
    end else if (state_q == ST_DIV) begin
      if (div_last) begin
        rem_q <= '0;
        case (op_q)
          OP_VWAP: begin
            if (new_q.vol_sum == '0) begin
              vwap_q <= '0;
            end else if (quo_next[63:32] != '0) begin
              vwap_q <= '1;
            end else begin
              vwap_q <= quo_next[31:0];
            end
            quo_q <= {ddnum_q, 5'd0};
            den_q <= 48'(new_q.peak);
          end
          OP_DD: begin
            dd_q  <= (new_q.peak != '0 && quo_next > 64'(new_q.dd)) ?
                     quo_next[26:0] : new_q.dd;
            quo_q <= {wsum_q, 30'd0};
            den_q <= 48'(new_q.fill);
          end
          default: mean_q <= quo_next[31:0];
        endcase
      end else begin
        rem_q <= fit ? 48'(rem_sh - 49'(den_q)) : rem_sh[47:0];
        quo_q <= quo_next;
      end
    end
  end

  // Record write-back.
  always_comb begin
    wr_rec      = new_q;
    wr_rec.anom = anom_q;
    wr_rec.dd   = dd_q;
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (mem_we) begin
      out_valid_o <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_o <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      out_symbol_o   <= sym_q;
      volume_total_o <= new_q.vol_sum;
      vwap_o         <= vwap_q;
      rolling_mean_o <= mean_q;
      anomalies_o    <= anom_q;
      drawdown_max_o <= dd_q;
      jump_flag_o    <= jump_q;
    end
  end

  // Checks on the update logic, the input stall and the loading of the output register.
  a_jump_counted: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && jump_flag_o |-> anomalies_o != '0)
    else $error("jump flagged but anomaly count is zero");

  a_dd_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> drawdown_max_o <= DD_SCALE)
    else $error("drawdown above full scale");

  a_busy_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q != ST_IDLE |-> in_stall_o)
    else $error("input taken while a transaction is in progress");

  a_result_loaded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |=> out_valid_o && state_q == ST_IDLE)
    else $error("result not presented after write-back");

endmodule

// ===== sim/tb_tick_stats_per_symbol.sv =====
// Testbench for the per-symbol tick statistics block.
// Drives ticks, predicts each symbol's statistics and checks every result transaction.
`timescale 1ns / 1ps

module tb_tick_stats_per_symbol
  import tsps_pkg::*;
();

  typedef struct packed {
    logic [7:0]  sym;
    logic [31:0] price;
    logic [23:0] vol;
  } tick_t;

  typedef struct packed {
    logic [7:0]  sym;
    logic [47:0] vtot;
    logic [31:0] vwap;
    logic [31:0] mean;
    logic [31:0] anom;
    logic [26:0] dd;
    logic        jump;
  } stats_t;

  logic clk, rst_n;
  logic cfg_we;
  logic [13:0] cfg_wdata;
  logic in_valid, in_stall, out_valid, out_stall;
  logic [7:0] symbol_id;
  logic [31:0] price;
  logic [23:0] volume;
  logic [7:0] o_sym;
  logic [47:0] o_vtot;
  logic [31:0] o_vwap, o_mean, o_anom;
  logic [26:0] o_dd;
  logic o_jump;

  tick_stats_per_symbol uut (
    .clk_i(clk), .rst_ni(rst_n), .cfg_we_i(cfg_we), .cfg_wdata_i(cfg_wdata),
    .in_valid_i(in_valid), .in_stall_o(in_stall), .symbol_id_i(symbol_id),
    .price_i(price), .volume_i(volume), .out_valid_o(out_valid),
    .out_stall_i(out_stall), .out_symbol_o(o_sym), .volume_total_o(o_vtot),
    .vwap_o(o_vwap), .rolling_mean_o(o_mean), .anomalies_o(o_anom),
    .drawdown_max_o(o_dd), .jump_flag_o(o_jump)
  );

  // Predictor state, one record per symbol.
  logic [13:0] thresh;
  logic [47:0] m_vsum [NUM_SYMBOLS];
  logic [63:0] m_notional [NUM_SYMBOLS];
  logic [31:0] m_win [NUM_SYMBOLS][WINDOW];
  int unsigned m_fill [NUM_SYMBOLS];
  int unsigned m_ptr [NUM_SYMBOLS];
  logic [31:0] m_prev [NUM_SYMBOLS];
  logic [31:0] m_peak [NUM_SYMBOLS];
  logic [26:0] m_dd [NUM_SYMBOLS];
  logic [31:0] m_anom [NUM_SYMBOLS];

  tick_t  pending_ticks[$];
  stats_t expected_stats[$];
  int     errors = 0;
  int     in_idle_pct = 0, out_stall_pct = 0;

  // Updates one symbol's record with a tick and returns the statistics it yields.
  function automatic stats_t apply_tick(tick_t t);
    stats_t r;
    logic [48:0] vs;
    logic [63:0] prod, ns;
    logic [33:0] wsum;
    logic [63:0] diff, dd, vw;
    logic [127:0] lhs;
    int s;
    r = '0;
    r.sym = t.sym;
    s = t.sym;
    if (s >= NUM_SYMBOLS) return r;
    vs = {1'b0, m_vsum[s]} + t.vol;
    if (vs[48]) vs = {1'b0, 48'hFFFF_FFFF_FFFF};
    m_vsum[s] = vs[47:0];
    prod = 64'(t.price) * 64'(t.vol);
    ns = m_notional[s] + prod;
    if (ns < prod) ns = '1;
    m_notional[s] = ns;
    m_win[s][m_ptr[s]] = t.price;
    m_ptr[s] = (m_ptr[s] + 1) % WINDOW;
    if (m_fill[s] < WINDOW) m_fill[s]++;
    wsum = 0;
    for (int i = 0; i < m_fill[s]; i++) wsum += m_win[s][i];
    if (m_prev[s] != 0) begin
      diff = (t.price >= m_prev[s]) ? 64'(t.price - m_prev[s]) : 64'(m_prev[s] - t.price);
      lhs = 128'(diff) * 10000;
      if (lhs >= 128'(thresh) * 128'(m_prev[s])) begin
        r.jump = 1'b1;
        if (m_anom[s] != 32'hFFFF_FFFF) m_anom[s]++;
      end
    end
    if (t.price > m_peak[s]) m_peak[s] = t.price;
    if (m_peak[s] != 0) begin
      dd = (64'(m_peak[s] - t.price) * 64'd100000000) / 64'(m_peak[s]);
      if (dd > 64'(m_dd[s])) m_dd[s] = dd[26:0];
    end
    m_prev[s] = t.price;
    vw = 0;
    if (vs != 0) begin
      vw = ns / 64'(vs[47:0]);
      if (vw > 64'hFFFF_FFFF) vw = 64'hFFFF_FFFF;
    end
    r.vtot = vs[47:0];
    r.vwap = vw[31:0];
    r.mean = 32'(wsum / m_fill[s]);
    r.anom = m_anom[s];
    r.dd = m_dd[s];
    return r;
  endfunction

  // Appends one tick to the driver's queue.
  task automatic add_tick(tick_t t);
    pending_ticks.insert(pending_ticks.size(), t);
  endtask

  // Clock generation.
  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  // Input driver: presents queued ticks and predicts each accepted one.
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      symbol_id <= '0;
      price <= '0;
      volume <= '0;
    end else begin
      if (in_valid && !in_stall) begin
        expected_stats.insert(expected_stats.size(), apply_tick({symbol_id, price, volume}));
        pending_ticks.delete(0);
      end
      if (!(in_valid && in_stall)) begin
        if (in_valid && !in_stall) begin
          if (pending_ticks.size() > 0 && $urandom_range(99) >= in_idle_pct) begin
            {symbol_id, price, volume} <= pending_ticks[0];
          end else begin
            in_valid <= 1'b0;
          end
        end else if (pending_ticks.size() > 0 && $urandom_range(99) >= in_idle_pct) begin
          in_valid <= 1'b1;
          {symbol_id, price, volume} <= pending_ticks[0];
        end
      end
    end
  end

  // Output monitor: random stall and field-by-field compare.
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_stats.size() == 0) begin
          $display("%0t: unexpected result transaction, symbol %0d", $time, o_sym);
          errors++;
        end else begin
          stats_t e;
          e = expected_stats[0];
          expected_stats.delete(0);
          if (e.sym !== o_sym) begin
            $display("%0t: out_symbol exp %0d got %0d", $time, e.sym, o_sym); errors++;
          end
          if (e.vtot !== o_vtot) begin
            $display("%0t: volume_total exp %0d got %0d", $time, e.vtot, o_vtot); errors++;
          end
          if (e.vwap !== o_vwap) begin
            $display("%0t: vwap exp %0d got %0d", $time, e.vwap, o_vwap); errors++;
          end
          if (e.mean !== o_mean) begin
            $display("%0t: rolling_mean exp %0d got %0d", $time, e.mean, o_mean); errors++;
          end
          if (e.anom !== o_anom) begin
            $display("%0t: anomalies exp %0d got %0d", $time, e.anom, o_anom); errors++;
          end
          if (e.dd !== o_dd) begin
            $display("%0t: drawdown_max exp %0d got %0d", $time, e.dd, o_dd); errors++;
          end
          if (e.jump !== o_jump) begin
            $display("%0t: jump_flag exp %0d got %0d", $time, e.jump, o_jump); errors++;
          end
        end
      end
      out_stall <= ($urandom_range(99) < out_stall_pct);
    end
  end

  function automatic tick_t rand_tick(int nsym);
    tick_t t;
    int sel;
    t.sym = 8'($urandom_range(nsym - 1));
    sel = $urandom_range(9);
    if (sel == 0) t.price = '1;
    else if (sel == 1) t.price = '0;
    else if (sel == 2) t.price = $urandom();
    else t.price = 32'd1000000 + $urandom_range(40000);
    sel = $urandom_range(5);
    if (sel == 0) t.vol = '1;
    else if (sel == 1) t.vol = '0;
    else if (sel == 2) t.vol = 24'($urandom());
    else t.vol = 24'($urandom_range(1000));
    return t;
  endfunction

  // Waits until all queued ticks are predicted and every result has arrived.
  task automatic drain();
    while (pending_ticks.size() > 0 || in_valid || expected_stats.size() > 0)
      @(posedge clk);
    repeat (400) @(posedge clk);
  endtask

  task automatic write_threshold(logic [13:0] v);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    thresh = v;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Stimulus: directed corner ticks, then random phases with varying idling.
  initial begin
    logic [13:0] thresholds [4];
    int idle_set [4][2];
    thresholds = '{14'd0, 14'd10000, 14'h3FFF, 14'd80};
    idle_set = '{'{0, 0}, '{65, 0}, '{0, 65}, '{13, 13}};
    rst_n = 0;
    cfg_we = 0;
    cfg_wdata = '0;
    thresh = THRESH_RESET;
    for (int s = 0; s < NUM_SYMBOLS; s++) begin
      m_vsum[s] = 0; m_notional[s] = 0; m_fill[s] = 0; m_ptr[s] = 0;
      m_prev[s] = 0; m_peak[s] = 0; m_dd[s] = 0; m_anom[s] = 0;
      for (int i = 0; i < WINDOW; i++) m_win[s][i] = 0;
    end
    repeat (10) @(posedge clk);
    rst_n <= 1;
    // Directed: default threshold, zero prices, peaks, extremes and saturation.
    add_tick('{8'd0, 32'd0, 24'd0});
    add_tick('{8'd0, 32'd1000000, 24'd10});
    add_tick('{8'd0, 32'd1008000, 24'd10});
    add_tick('{8'd0, 32'd1008001, 24'd10});
    add_tick('{8'd0, 32'd0, 24'd5});
    add_tick('{8'd0, 32'd500, 24'd5});
    add_tick('{8'd255, 32'hFFFF_FFFF, 24'hFF_FFFF});
    add_tick('{8'd255, 32'hFFFF_FFFF, 24'hFF_FFFF});
    add_tick('{8'd255, 32'd1, 24'hFF_FFFF});
    add_tick('{8'd255, 32'hFFFF_FFFF, 24'd0});
    add_tick('{8'd170, 32'hAAAA_AAAA, 24'hAA_AAAA});
    add_tick('{8'd85, 32'h5555_5555, 24'h55_5555});
    add_tick('{8'd1, 32'd7, 24'd1});
    add_tick('{8'd1, 32'd7, 24'd1});
    drain();
    // Accumulate one symbol's volume over repeated maximum-volume ticks.
    for (int i = 0; i < 12; i++) add_tick('{8'd2, 32'd3, 24'hFF_FFFF});
    drain();
    for (int ph = 0; ph < 4; ph++) begin
      write_threshold(thresholds[ph]);
      in_idle_pct = idle_set[ph][0];
      out_stall_pct = idle_set[ph][1];
      for (int n = 0; n < 460; n++) begin
        add_tick(rand_tick((n % 3 == 0) ? 256 : 8));
      end
      drain();
      write_threshold(14'($urandom_range(300)));
    end
    if (errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // Timeout guard.
  initial begin
    #8000000;
    $display("Mismatches found");
    $finish;
  end

endmodule
